@@ design/sfm_pkg.sv @@
`default_nettype none

package sfm_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_SAMPLE_RATE = 11025;
    localparam int DEF_PHASE_BITS  = 32;
    localparam int DEF_TABLE_DEPTH = 1024;

    // Frequencies are carried as hertz times this scale, so pixel tones stay exact.
    localparam int FDEN = 4080;
    localparam int F_W  = 24;

    // Peak amplitude, 0.95 of full scale.
    localparam longint AMP   = 31129;
    localparam int     AMP_W = 15;

    localparam longint Q30_ONE    = 64'sd1073741824;
    localparam longint Q30_HALFPI = 64'sd1686629713;

    localparam int HZ_W   = 12;
    localparam int PIX_W  = 8;
    localparam int CMD_W  = 2;
    localparam int SMP_W  = 16;
    localparam int CIDX_W = 2;

    // Command codes; any code from CMD_SILENCE upward gives a zero sample.
    localparam logic [CMD_W-1:0] CMD_TONE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PIXEL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SILENCE = 2'd2;

    // Register indexes and reset values.
    localparam logic [CIDX_W-1:0] REG_BLACK = 2'd0;
    localparam logic [CIDX_W-1:0] REG_WHITE = 2'd1;
    localparam logic [HZ_W-1:0]   BLACK_RST = 12'd1500;
    localparam logic [HZ_W-1:0]   WHITE_RST = 12'd2300;

    typedef struct packed {
        logic capture;
        logic calc_freq;
        logic mul_est;
        logic rem_calc;
        logic phase_upd;
        logic lookup;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic silence;
        logic out_free;
    } dp_status_t;

    // Quarter-wave magnitude of the cosine (want_sin low) or sine (want_sin high)
    // at table step j, for a table of 2**depth_log2 entries. Evaluated at
    // elaboration only: Q30 angle, nine-term Taylor series, round half up.
    function automatic logic [AMP_W-1:0] trig_mag(input int unsigned j,
                                                  input int unsigned depth_log2,
                                                  input logic want_sin);
        longint unsigned y;
        longint unsigned x2;
        longint unsigned tc;
        longint unsigned ts;
        longint sc;
        longint ss;
        longint v;
        longint m;
        y  = (longint'(j) * 4 * Q30_HALFPI) >> depth_log2;
        x2 = (y * y) >> 30;
        tc = Q30_ONE;
        ts = y;
        sc = Q30_ONE;
        ss = longint'(y);
        for (int n = 1; n <= 8; n++)
        begin
            tc = (tc * x2) >> 30;
            ts = (ts * x2) >> 30;
            case (n)
                1: begin tc = tc / 64'd2;   ts = ts / 64'd6;   end
                2: begin tc = tc / 64'd12;  ts = ts / 64'd20;  end
                3: begin tc = tc / 64'd30;  ts = ts / 64'd42;  end
                4: begin tc = tc / 64'd56;  ts = ts / 64'd72;  end
                5: begin tc = tc / 64'd90;  ts = ts / 64'd110; end
                6: begin tc = tc / 64'd132; ts = ts / 64'd156; end
                7: begin tc = tc / 64'd182; ts = ts / 64'd210; end
                8: begin tc = tc / 64'd240; ts = ts / 64'd272; end
                default: ;
            endcase
            if ((n % 2) == 1)
            begin
                sc = sc - longint'(tc);
                ss = ss - longint'(ts);
            end
            else
            begin
                sc = sc + longint'(tc);
                ss = ss + longint'(ts);
            end
        end
        v = want_sin ? ss : sc;
        m = (v < 0) ? -v : v;
        m = (m * AMP + (Q30_ONE / 2)) >>> 30;
        return m[AMP_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ design/sfm_cos_rom.sv @@
`default_nettype none

module sfm_cos_rom
    import sfm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  wire logic                           clk,
    input  wire logic                           rd_en,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] addr,
    output logic signed [SMP_W-1:0]             data
);

    localparam int TB = $clog2(TABLE_DEPTH);
    localparam int QD = TABLE_DEPTH / 4;

    // One quarter wave of cosine and of sine; the quadrant picks one and a sign.
    logic [AMP_W-1:0] cos_mag [QD];
    logic [AMP_W-1:0] sin_mag [QD];

    for (genvar j = 0; j < QD; j++)
    begin : g_tab
        localparam logic [AMP_W-1:0] CM = trig_mag(j, TB, 1'b0);
        localparam logic [AMP_W-1:0] SM = trig_mag(j, TB, 1'b1);
        assign cos_mag[j] = CM;
        assign sin_mag[j] = SM;
    end

    logic [AMP_W-1:0]        mag;
    logic                    neg;
    logic signed [SMP_W-1:0] value;

    always_comb
    begin
        mag   = addr[TB-2] ? sin_mag[addr[TB-3:0]] : cos_mag[addr[TB-3:0]];
        // Second and third quadrants are negative.
        neg   = addr[TB-1] ^ addr[TB-2];
        value = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data <= value;
        end
    end

endmodule

`default_nettype wire

@@ design/sfm_dp.sv @@
`default_nettype none

module sfm_dp
    import sfm_pkg::*;
#(
    parameter int SAMPLE_RATE = DEF_SAMPLE_RATE,
    parameter int PHASE_BITS  = DEF_PHASE_BITS,
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire ctrl_cmd_t               cmd,
    output dp_status_t                   stat,
    input  wire logic [CMD_W-1:0]        command,
    input  wire logic [HZ_W-1:0]         freq_hz,
    input  wire logic [PIX_W-1:0]        pixel,
    input  wire logic                    cfg_valid,
    input  wire logic [CIDX_W-1:0]       cfg_index,
    input  wire logic [HZ_W-1:0]         cfg_data,
    input  wire logic                    out_ready,
    output logic                         out_valid,
    output logic signed [SMP_W-1:0]      sample
);

    localparam int TB = $clog2(TABLE_DEPTH);
    localparam longint unsigned DEN = longint'(FDEN) * longint'(SAMPLE_RATE);
    localparam int DW = $clog2(DEN + 1);
    // The remainder after the estimate stays below three times DEN.
    localparam int RW = DW + 2;
    localparam int PW = F_W + PHASE_BITS;
    localparam logic [PHASE_BITS-1:0] RECIP  =
        PHASE_BITS'((64'd1 << (PHASE_BITS + F_W)) / DEN);
    localparam logic [RW-1:0]         DEN_R  = RW'(DEN);
    localparam logic [RW-1:0]         DEN2_R = RW'(2 * DEN);
    localparam logic [RW-1:0]         HALF_R = RW'(DEN / 2);

    logic [CMD_W-1:0]        cmd_reg;
    logic [HZ_W-1:0]         freq_reg;
    logic [PIX_W-1:0]        pixel_reg;
    logic [HZ_W-1:0]         black_reg;
    logic [HZ_W-1:0]         white_reg;
    logic [F_W-1:0]          f4080_reg;
    logic [RW-1:0]           rem_reg;
    logic [PHASE_BITS-1:0]   quo_reg;
    logic [PHASE_BITS-1:0]   phase_reg;
    logic signed [SMP_W-1:0] sample_reg;
    logic                    out_valid_reg;
    logic signed [SMP_W-1:0] rom_data;

    // Frequency scaled by FDEN: exact for both tone and pixel commands.
    logic signed [HZ_W:0]   diff;
    logic [HZ_W-1:0]        weight;
    logic signed [25:0]     prod;
    logic signed [25:0]     base;
    logic signed [25:0]     fsum;
    logic [F_W-1:0]         f_tone;
    logic [F_W-1:0]         f_pix;

    assign diff   = $signed({1'b0, white_reg}) - $signed({1'b0, black_reg});
    assign weight = HZ_W'(pixel_reg) * 12'd15 + 12'd255;
    assign prod   = 26'(diff) * $signed({14'd0, weight});
    assign base   = $signed(26'(black_reg) * 26'(FDEN));
    assign fsum   = base + prod;
    assign f_pix  = fsum[25] ? '0 : fsum[F_W-1:0];
    assign f_tone = F_W'(freq_reg) * F_W'(FDEN);

    // Phase increment: the reciprocal multiply lands at most two below the
    // rounded quotient, and the remainder against DEN tells how far.
    logic [PW-1:0] est_prod;
    logic [RW-1:0] num_low;
    logic [RW-1:0] qd_low;
    logic [1:0]    corr;

    assign est_prod = PW'(f4080_reg) * PW'(RECIP);
    assign num_low  = RW'({f4080_reg, {PHASE_BITS{1'b0}}}) + HALF_R;
    assign qd_low   = RW'(quo_reg) * DEN_R;
    assign corr     = (rem_reg >= DEN2_R) ? 2'd2 : ((rem_reg >= DEN_R) ? 2'd1 : 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_reg     <= BLACK_RST;
            white_reg     <= WHITE_RST;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_BLACK: black_reg <= cfg_data;
                    REG_WHITE: white_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.phase_upd)
            begin
                phase_reg <= phase_reg + quo_reg + PHASE_BITS'(corr);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg   <= command;
            freq_reg  <= freq_hz;
            pixel_reg <= pixel;
        end
        if (cmd.calc_freq)
        begin
            f4080_reg <= (cmd_reg == CMD_PIXEL) ? f_pix : f_tone;
        end
        if (cmd.mul_est)
        begin
            quo_reg <= est_prod[F_W +: PHASE_BITS];
        end
        if (cmd.rem_calc)
        begin
            rem_reg <= num_low - qd_low;
        end
        if (cmd.out_load)
        begin
            sample_reg <= stat.silence ? '0 : rom_data;
        end
    end

    sfm_cos_rom #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_rom (
        .clk  (clk),
        .rd_en(cmd.lookup),
        .addr (phase_reg[PHASE_BITS-1 -: TB]),
        .data (rom_data)
    );

    assign stat.silence  = cmd_reg >= CMD_SILENCE;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

endmodule

`default_nettype wire

@@ design/sfm_ctrl.sv @@
`default_nettype none

module sfm_ctrl
    import sfm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t stat,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FREQ,
        ST_MUL,
        ST_REM,
        ST_PHASE,
        ST_LOOK,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        in_ready_next = in_ready_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.capture   = 1'b1;
                    state_next    = ST_FREQ;
                    in_ready_next = 1'b0;
                end
            end
            ST_FREQ:
            begin
                cmd.calc_freq = 1'b1;
                state_next    = stat.silence ? ST_EMIT : ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_est = 1'b1;
                state_next  = ST_REM;
            end
            ST_REM:
            begin
                cmd.rem_calc = 1'b1;
                state_next   = ST_PHASE;
            end
            ST_PHASE:
            begin
                cmd.phase_upd = 1'b1;
                state_next    = ST_LOOK;
            end
            ST_LOOK:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    state_next    = ST_IDLE;
                    in_ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next    = ST_IDLE;
                in_ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    assign in_ready = in_ready_reg;

endmodule

`default_nettype wire

@@ design/sstv_fm_tone_modulator_core.sv @@
`default_nettype none

// Phase-continuous FM tone generator for SSTV audio: one sample per input beat.
// Input channel (in_valid/in_ready) carries command, freq_hz and pixel. A tone
// command advances the phase by freq_hz, a pixel command by the tone between
// black_hz and white_hz set by the pixel value, and silence gives a zero sample
// without touching the phase. The sample is a cosine table read of the new phase.
// Configuration (cfg_valid/cfg_ready, always ready) writes black_hz at index 0
// and white_hz at index 1; other indexes are ignored. Write only while idle.
// The block is ready for a new beat in the same cycle that out_valid rises. An
// item passes in order through the frequency, a reciprocal multiply that
// estimates the phase increment, the remainder that corrects the estimate, the
// phase update, the table read and the output load. Silence goes straight from
// the frequency to the output load. One item is in flight at a time.
// The result sits in an output register; if the receiver stalls, the next input
// beat is still taken and worked up to the table read, then waits for the
// register to free. Reset clears the phase, restores 1500 Hz and 2300 Hz, and
// leaves the block ready with no output pending.
module sstv_fm_tone_modulator_core
    import sfm_pkg::*;
#(
    parameter int SAMPLE_RATE = DEF_SAMPLE_RATE,
    parameter int PHASE_BITS  = DEF_PHASE_BITS,
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [CMD_W-1:0]    command,
    input  wire logic [HZ_W-1:0]     freq_hz,
    input  wire logic [PIX_W-1:0]    pixel,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [SMP_W-1:0]  sample,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CIDX_W-1:0]   cfg_index,
    input  wire logic [HZ_W-1:0]     cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    assign cfg_ready = 1'b1;

    sfm_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sfm_dp #(
        .SAMPLE_RATE(SAMPLE_RATE),
        .PHASE_BITS (PHASE_BITS),
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .command  (command),
        .freq_hz  (freq_hz),
        .pixel    (pixel),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .out_ready(out_ready),
        .out_valid(out_valid),
        .sample   (sample)
    );

endmodule

`default_nettype wire

@@ design/sfm_checker.sv @@
`default_nettype none

module sfm_checker
    import sfm_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_ready,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic signed [SMP_W-1:0] sample
);

    // A stalled output beat keeps its sample.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample))
        else $error("output beat changed while stalled");

    // Only one item is worked at a time: an input beat makes the block busy.
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input still ready right after a beat");

    // Ready drops only because a beat was taken.
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("input ready fell without a beat");

    // A new result leaves the block ready for the next item.
    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result posted while input not ready");

endmodule

bind sstv_fm_tone_modulator_core sfm_checker u_sfm_checker (.*);

`default_nettype wire
